// ===== sv/ejd_pkg.sv =====
// Shared constants and types for the EUC-JP byte stream decoder.
// Holds the shift codes, the code class bases and the decode phase type.
// No dependencies.
package ejd_pkg;

  // Single shift codes that open a kana or a supplementary kanji sequence.
  localparam logic [7:0] SS2_BYTE = 8'h8E;
  localparam logic [7:0] SS3_BYTE = 8'h8F;

  // Class bases of the packed character code.
  localparam logic [15:0] KANA_BASE  = 16'h0080;
  localparam logic [15:0] SS3_BASE   = 16'h8000;
  localparam logic [15:0] KANJI_BASE = 16'h8080;

  // Width of one seven-bit half of a code.
  localparam int unsigned HALF_W = 7;

  // Decode phase, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SS2    = 5'b00010,
    PH_SS3_HI = 5'b00100,
    PH_SS3_LO = 5'b01000,
    PH_KANJI  = 5'b10000
  } phase_e;

endpackage

// ===== sv/euc_jp_byte_stream_decoder_unit.sv =====
// Path: an accepted byte enters the input register, and a result word is presented from the
// result register. Throughput: one byte per cycle, set by the single decode pass that
// sits between the input register and the result register; a stalled result word blocks
// intake only once the input register also holds a byte.
// Reset: rst_ni clears both valid flags, returns the phase to idle and the held half to zero.
// Top level of the EUC-JP byte stream decoder; uses ejd_pkg.
module euc_jp_byte_stream_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] char_code_o,
  output logic        truncated_o,
  output logic        last_out_o
);

  // Input register.
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;

  // Decode state.
  ejd_pkg::phase_e           phase_q, phase_d;
  logic [ejd_pkg::HALF_W-1:0] held_q, held_d;

  // Result register.
  logic        out_valid_q;
  logic [15:0] out_code_q;
  logic        out_trunc_q;
  logic        out_last_q;

  // Decode outputs.
  logic        done;
  logic        emit;
  logic [15:0] code;
  logic [15:0] res_code;
  logic        res_trunc;
  logic [ejd_pkg::HALF_W-1:0] low7;

  logic out_free;
  logic s1_free;
  logic s1_adv;

  // Flow control: the result register frees when empty or taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;

  // Decode pass over the registered byte and the current phase.
  always_comb begin
    low7    = s1_byte_q[ejd_pkg::HALF_W-1:0];
    done    = 1'b0;
    code    = 16'h0000;
    phase_d = ejd_pkg::PH_IDLE;
    held_d  = held_q;
    case (phase_q)
      ejd_pkg::PH_SS2: begin
        code = ejd_pkg::KANA_BASE | {9'd0, low7};
        done = 1'b1;
      end
      ejd_pkg::PH_SS3_HI: begin
        held_d  = low7;
        phase_d = ejd_pkg::PH_SS3_LO;
      end
      ejd_pkg::PH_SS3_LO: begin
        code = ejd_pkg::SS3_BASE | {1'b0, held_q, 1'b0, low7};
        done = 1'b1;
      end
      ejd_pkg::PH_KANJI: begin
        code = ejd_pkg::KANJI_BASE | {1'b0, held_q, 1'b0, low7};
        done = 1'b1;
      end
      default: begin
        if (!s1_byte_q[7]) begin
          code = {8'd0, s1_byte_q};
          done = 1'b1;
        end else if (s1_byte_q == ejd_pkg::SS2_BYTE) begin
          phase_d = ejd_pkg::PH_SS2;
        end else if (s1_byte_q == ejd_pkg::SS3_BYTE) begin
          phase_d = ejd_pkg::PH_SS3_HI;
        end else begin
          held_d  = low7;
          phase_d = ejd_pkg::PH_KANJI;
        end
      end
    endcase
    // The final byte of a string always ends the character and drops held bytes.
    if (s1_last_q) begin
      phase_d = ejd_pkg::PH_IDLE;
      held_d  = '0;
    end
    emit      = done || s1_last_q;
    res_trunc = !done;
    res_code  = done ? code : 16'h0000;
  end

  // Input register loads whenever it is empty or moving on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Decode state advances with each byte that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ejd_pkg::PH_IDLE;
      held_q  <= '0;
    end else if (s1_adv) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_code_q  <= res_code;
      out_trunc_q <= res_trunc;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = out_code_q;
  assign truncated_o = out_trunc_q;
  assign last_out_o  = out_last_q;

`ifndef NO_ASSERTIONS
  // A truncated word carries a zero code and is always the end of a string.
  a_trunc_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_trunc_q) |-> (out_code_q == 16'h0000 && out_last_q))
    else $error("truncated word with nonzero code or without last flag");

  // A final byte that leaves the input register always produces a word.
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (out_valid_q && out_last_q))
    else $error("final byte produced no word");

  // After a final byte the decoder is back at idle with nothing held.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (phase_q == ejd_pkg::PH_IDLE && held_q == '0))
    else $error("decoder not idle after final byte");

  // The phase register stays one-hot.
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");
`endif

endmodule

// ===== tb/sv/euc_jp_byte_stream_decoder_unit_test.sv =====
// Self-checking testbench for the EUC-JP byte stream decoder unit.
// Drives byte words, predicts each character code and checks every result word.
// Depends on ejd_pkg and euc_jp_byte_stream_decoder_unit.
`timescale 1ns / 100ps

module euc_jp_byte_stream_decoder_unit_test;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // One decoded character as it leaves the block.
  typedef struct packed {
    logic [15:0] code;
    logic        trunc;
    logic        last;
  } char_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] char_code_o;
  logic        truncated_o;
  logic        last_out_o;

  // Decoder state as predicted from the accepted bytes.
  ejd_pkg::phase_e pred_phase;
  logic [6:0]  pred_held;
  char_word_t  expected_chars[$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned stall_left;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          hold_rx;

  euc_jp_byte_stream_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .truncated_o (truncated_o),
    .last_out_o  (last_out_o)
  );

  // Free-running clock with a 4 ns period.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Advance the predicted decoder by one byte and queue the character it completes.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [6:0]  low7;
    logic        done;
    logic [15:0] code;
    low7 = b[6:0];
    done = 1'b0;
    code = '0;
    case (pred_phase)
      ejd_pkg::PH_SS2: begin
        code = ejd_pkg::KANA_BASE | {9'd0, low7};
        done = 1'b1;
        pred_phase = ejd_pkg::PH_IDLE;
      end
      ejd_pkg::PH_SS3_HI: begin
        pred_held = low7;
        pred_phase = ejd_pkg::PH_SS3_LO;
      end
      ejd_pkg::PH_SS3_LO: begin
        code = ejd_pkg::SS3_BASE | {1'b0, pred_held, 1'b0, low7};
        done = 1'b1;
        pred_phase = ejd_pkg::PH_IDLE;
      end
      ejd_pkg::PH_KANJI: begin
        code = ejd_pkg::KANJI_BASE | {1'b0, pred_held, 1'b0, low7};
        done = 1'b1;
        pred_phase = ejd_pkg::PH_IDLE;
      end
      default: begin
        if (!b[7]) begin
          code = {8'h00, b};
          done = 1'b1;
          pred_phase = ejd_pkg::PH_IDLE;
        end else if (b == ejd_pkg::SS2_BYTE) begin
          pred_phase = ejd_pkg::PH_SS2;
        end else if (b == ejd_pkg::SS3_BYTE) begin
          pred_phase = ejd_pkg::PH_SS3_HI;
        end else begin
          pred_held = low7;
          pred_phase = ejd_pkg::PH_KANJI;
        end
      end
    endcase
    // A final byte always yields a word; an unfinished character comes out truncated.
    if (done) begin
      expected_chars.push_back('{code: code, trunc: 1'b0, last: last});
    end else if (last) begin
      expected_chars.push_back('{code: 16'h0000, trunc: 1'b1, last: 1'b1});
    end
    if (last) begin
      pred_phase = ejd_pkg::PH_IDLE;
      pred_held = '0;
    end
  endtask

  // Offer one byte word after a random gap and wait until it is taken.
  task automatic send_word(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    in_byte_i   = b;
    last_byte_i = last;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send a byte of a random stream, ending the string now and then.
  task automatic send_stream_byte(input logic [7:0] b);
    send_word(b, $urandom_range(0, 9) == 0);
  endtask

  // Receiver side: random stall after each word, plus the long hold-off.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        out_stall_i = 1'b1;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Compare every taken result word with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    char_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected word, code", int'(char_code_o), 0);
      end else begin
        want = expected_chars.pop_front();
        if (char_code_o !== want.code)
          report_mismatch("char_code", int'(char_code_o), int'(want.code));
        if (truncated_o !== want.trunc)
          report_mismatch("truncated", int'(truncated_o), int'(want.trunc));
        if (last_out_o !== want.last)
          report_mismatch("last_out", int'(last_out_o), int'(want.last));
      end
      stall_left = rx_idle_en ? $urandom_range(0, 6) : 0;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ASCII extremes pass through unchanged.
  task automatic test_ascii();
    send_word(8'h00, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h41, 1'b1);
  endtask

  // Half-width kana, with trail bytes of both top-bit values.
  task automatic test_kana();
    send_word(ejd_pkg::SS2_BYTE, 1'b0);
    send_word(8'hA1, 1'b0);
    send_word(ejd_pkg::SS2_BYTE, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(ejd_pkg::SS2_BYTE, 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  // Supplementary kanji through the three-byte sequence.
  task automatic test_ss3();
    send_word(ejd_pkg::SS3_BYTE, 1'b0);
    send_word(8'hA1, 1'b0);
    send_word(8'hFE, 1'b0);
    send_word(ejd_pkg::SS3_BYTE, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h00, 1'b1);
  endtask

  // Two-byte kanji with the lowest and highest lead bytes.
  task automatic test_kanji();
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
  endtask

  // A string that ends inside a character gives a truncated word and restarts.
  task automatic test_truncation();
    send_word(ejd_pkg::SS2_BYTE, 1'b1);
    send_word(ejd_pkg::SS3_BYTE, 1'b0);
    send_word(8'hA1, 1'b1);
    send_word(ejd_pkg::SS3_BYTE, 1'b1);
    send_word(8'hC0, 1'b1);
    send_word(8'h30, 1'b1);
  endtask

  // Mostly well-formed characters with random content, some stray bytes.
  task automatic test_random_streams(input int unsigned n_bytes);
    int unsigned start;
    logic [7:0]  lead;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_stream_byte({1'b0, 7'($urandom_range(0, 127))});
        3, 4: begin
          send_stream_byte(ejd_pkg::SS2_BYTE);
          send_stream_byte(8'($urandom_range(0, 255)));
        end
        5: begin
          send_stream_byte(ejd_pkg::SS3_BYTE);
          send_stream_byte(8'($urandom_range(0, 255)));
          send_stream_byte(8'($urandom_range(0, 255)));
        end
        6, 7: begin
          do lead = 8'($urandom_range(8'h80, 8'hFF));
          while (lead == ejd_pkg::SS2_BYTE || lead == ejd_pkg::SS3_BYTE);
          send_stream_byte(lead);
          send_stream_byte(8'($urandom_range(0, 255)));
        end
        default: send_stream_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Full rate on both sides with no idle cycles at all.
  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_streams(80);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Receiver holds off for a long stretch while ASCII words keep coming.
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    fork
      begin
        hold_rx = 1'b1;
        repeat (80) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      repeat (40) send_word({1'b0, 7'($urandom_range(0, 127))}, 1'b0);
    join
    tx_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = '0;
    last_byte_i = 1'b0;
    pred_phase  = ejd_pkg::PH_IDLE;
    pred_held   = '0;
    error_count = 0;
    cycle_count = 0;
    bytes_sent  = 0;
    stall_left  = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    hold_rx     = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_ascii();
    test_kana();
    test_ss3();
    test_kanji();
    test_truncation();
    test_random_streams(250);
    test_full_rate();
    test_backpressure();
    test_random_streams(110);

    // Drain every outstanding word, then allow the pipeline to settle.
    in_valid_i = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
